// ===== rtl/core/pcik_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcik_pkg: shared types and constants of the planar chain IK solver
// Fixed field widths, configuration register indexes and the request and
// response bundles of the shared vector scaling unit.
// -----------------------------------------------------------------------------
package pcik_pkg;

  localparam int MAX_BONES_DEF = 8;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CW    = 24;   // coordinate width, signed
  localparam int VW    = 26;   // difference vector width, signed
  localparam int MAGW  = 26;   // vector component magnitude
  localparam int SQW   = 52;   // exact sum of squares
  localparam int SLW   = 23;   // target length of a scaled vector
  localparam int ROOTW = 32;   // integer square root
  localparam int NUMW  = 55;   // rounded division numerator and quotient

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BONE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEND_SHIFT  = 2'd3;

  localparam logic signed [CW-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] CMIN = 24'sh800000;
  localparam logic [SLW-1:0] SLEN_MAX = 23'h7FFFFF;

  typedef struct packed {
    logic                  start;
    logic                  tot;     // sum of squares only
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic [SLW-1:0]        slen;
  } pcik_vreq_t;

  typedef struct packed {
    logic            done;
    logic [SQW-1:0]  sq;
  } pcik_vrsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/pcik_vec_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcik_vec_unit: shared vector scaling unit, also used for a sum of squares
// Rescales a vector to a given length: exact sum of squares, bit-serial
// integer square root, then a bit-serial rounded divide per component.
// -----------------------------------------------------------------------------
module pcik_vec_unit import pcik_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pcik_vreq_t        req,
  output pcik_vrsp_t             rsp,
  output logic signed [CW-1:0]   ox,
  output logic signed [CW-1:0]   oy
);

  typedef enum logic [2:0] {
    U_IDLE, U_MULX, U_MULY, U_CHK, U_SQRT, U_NUM, U_DIV, U_FIN
  } ustate_t;

  localparam logic [NUMW-1:0] QPOS = NUMW'(2**(CW-1) - 1);
  localparam logic [NUMW-1:0] QNEG = NUMW'(2**(CW-1));

  ustate_t               st_r;
  logic                  tot_r;
  logic                  sel_y_r;
  logic                  done_r;
  logic signed [VW-1:0]  vx_r, vy_r;
  logic [SLW-1:0]        slen_r;
  logic [SQW-1:0]        sq_r;
  logic [63:0]           x_r;
  logic [ROOTW-1:0]      root_r;
  logic [ROOTW:0]        rem_r;
  logic [NUMW-1:0]       num_r;
  logic [ROOTW-1:0]      drem_r;
  logic [NUMW-1:0]       quot_r;
  logic [5:0]            cnt_r;
  logic signed [CW-1:0]  ox_r, oy_r;

  logic [MAGW-1:0]       ax, ay, cur;
  logic                  neg;
  logic [2*MAGW-1:0]     prod;
  logic [MAGW+SLW-1:0]   mprod;
  logic [ROOTW+2:0]      rem_sh, trial;
  logic [ROOTW:0]        dsh;
  logic signed [CW-1:0]  qsat;

  assign ax    = vx_r[VW-1] ? MAGW'(-vx_r) : MAGW'(vx_r);
  assign ay    = vy_r[VW-1] ? MAGW'(-vy_r) : MAGW'(vy_r);
  assign cur   = sel_y_r ? ay : ax;
  assign neg   = sel_y_r ? vy_r[VW-1] : vx_r[VW-1];
  assign prod  = cur * cur;
  assign mprod = cur * slen_r;
  assign rem_sh = {rem_r, x_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign dsh    = {drem_r, num_r[NUMW-1]};

  always_comb begin
    if (!neg) begin
      qsat = (quot_r > QPOS) ? CMAX : quot_r[CW-1:0];
    end else begin
      qsat = (quot_r > QNEG) ? CMIN : CW'(~quot_r[CW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= U_IDLE;
      done_r  <= 1'b0;
      sel_y_r <= 1'b0;
      tot_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (req.start) begin
            vx_r    <= req.vx;
            vy_r    <= req.vy;
            slen_r  <= req.slen;
            tot_r   <= req.tot;
            sel_y_r <= 1'b0;
            st_r    <= U_MULX;
          end
        end
        U_MULX: begin
          sq_r    <= SQW'(prod);
          sel_y_r <= 1'b1;
          st_r    <= U_MULY;
        end
        U_MULY: begin
          sq_r <= sq_r + SQW'(prod);
          st_r <= U_CHK;
        end
        U_CHK: begin
          if (tot_r) begin
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end else if (sq_r == '0) begin
            ox_r   <= '0;
            oy_r   <= '0;
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end else begin
            x_r    <= {sq_r, 12'b0};
            root_r <= '0;
            rem_r  <= '0;
            cnt_r  <= 6'(ROOTW - 1);
            st_r   <= U_SQRT;
          end
        end
        U_SQRT: begin
          // one root bit per step, two radicand bits shifted in
          if (rem_sh >= trial) begin
            rem_r  <= (ROOTW+1)'(rem_sh - trial);
            root_r <= {root_r[ROOTW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[ROOTW:0];
            root_r <= {root_r[ROOTW-2:0], 1'b0};
          end
          x_r   <= {x_r[61:0], 2'b00};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            sel_y_r <= 1'b0;
            st_r    <= U_NUM;
          end
        end
        U_NUM: begin
          // |vx or vy| * len * 64 + divisor / 2, round half away from zero
          num_r  <= NUMW'({mprod, 6'b0}) + NUMW'(root_r[ROOTW-1:1]);
          drem_r <= '0;
          quot_r <= '0;
          cnt_r  <= 6'(NUMW - 1);
          st_r   <= U_DIV;
        end
        U_DIV: begin
          if (dsh >= {1'b0, root_r}) begin
            drem_r <= ROOTW'(dsh - {1'b0, root_r});
            quot_r <= {quot_r[NUMW-2:0], 1'b1};
          end else begin
            drem_r <= dsh[ROOTW-1:0];
            quot_r <= {quot_r[NUMW-2:0], 1'b0};
          end
          num_r <= {num_r[NUMW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            st_r <= U_FIN;
          end
        end
        U_FIN: begin
          if (!sel_y_r) begin
            ox_r    <= qsat;
            sel_y_r <= 1'b1;
            st_r    <= U_NUM;
          end else begin
            oy_r   <= qsat;
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.sq   = sq_r;
  assign ox       = ox_r;
  assign oy       = oy_r;

endmodule
`default_nettype wire

// ===== rtl/core/planar_chain_ik_solver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// planar_chain_ik_solver: planar chain inverse kinematics, reaching passes
// Holds joint positions, solves toward a target and streams joints 1..n.
// -----------------------------------------------------------------------------
// A load transaction writes one joint. A solve transaction moves the end
// joint to the target, computes one bend offset per bone, runs the backward
// and forward reaching passes and then streams joints 1..n. Every bone step
// goes through one shared scaling unit (32-step square root and one 55-step
// divider run once per component). in_ready is low for the whole solve,
// until its last joint is taken into the output register. The last joint
// of a solve may wait in the output register while the next transaction is
// taken.
// -----------------------------------------------------------------------------
module planar_chain_ik_solver import pcik_pkg::*; #(
  parameter int MAX_BONES = MAX_BONES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DW-1:0]     cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_mode,
  input  wire logic [3:0]            in_joint_index,
  input  wire logic signed [CW-1:0]  in_coord_x,
  input  wire logic signed [CW-1:0]  in_coord_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 out_index,
  output logic signed [CW-1:0]       out_x,
  output logic signed [CW-1:0]       out_y,
  output logic                       out_last
);

  localparam int JAW = $clog2(MAX_BONES + 1);
  localparam int BAW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOT, ST_TOT_WAIT, ST_F_A, ST_F_B, ST_F_C, ST_V_WAIT,
    ST_WB, ST_RSTART, ST_O_RD, ST_O_CAP
  } state_t;

  typedef enum logic [1:0] { OP_BEND, OP_BACK, OP_FWD } op_t;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [CW:0] v);
    if (v[CW] != v[CW-1]) begin
      return v[CW] ? CMIN : CMAX;
    end
    return v[CW-1:0];
  endfunction

  // configuration
  logic [3:0]  joint_count_r;
  logic [11:0] bone_length_r;
  logic [3:0]  iter_count_r;
  logic [3:0]  bend_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= 4'd2;
      bone_length_r <= 12'd100;
      iter_count_r  <= 4'd10;
      bend_shift_r  <= 4'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_JOINT_COUNT: joint_count_r <= cfg_wdata[3:0];
        CFG_BONE_LENGTH: bone_length_r <= cfg_wdata[11:0];
        CFG_ITER_COUNT:  iter_count_r  <= cfg_wdata[3:0];
        CFG_BEND_SHIFT:  bend_shift_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  state_t                st_r;
  op_t                   op_r;
  logic [JAW-1:0]        n_r, p_r;
  logic [3:0]            r_r;
  logic signed [CW-1:0]  tgt_x_r, tgt_y_r;
  logic signed [CW-1:0]  pv_x_r, pv_y_r;
  logic signed [CW-1:0]  base_x_r, base_y_r;
  logic [SLW-1:0]        bend_s_r;
  pcik_vreq_t            req_r;
  pcik_vrsp_t            rsp;
  logic signed [CW-1:0]  vox, voy;
  logic                  out_valid_r, out_last_r;
  logic [3:0]            out_index_r;
  logic signed [CW-1:0]  out_x_r, out_y_r;

  // joint and bend stores: {x, y}
  logic [2*CW-1:0] jmem [0:MAX_BONES];
  logic [2*CW-1:0] bmem [0:MAX_BONES-1];
  logic [2*CW-1:0] jrd_r, brd_r;
  logic            jw_en, bw_en;
  logic [JAW-1:0]  jw_addr, jr_addr, q_addr;
  logic [2*CW-1:0] jw_data;

  logic [JAW-1:0]  n_cl;
  logic [31:0]     bl_w;
  logic [SLW-1:0]  bone_s;
  logic [SQW-1:0]  stot_sh;
  logic            in_acc, out_free;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign q_addr   = (op_r == OP_FWD) ? p_r - 1'b1 : p_r + 1'b1;

  always_comb begin
    if (joint_count_r == 4'd0) begin
      n_cl = JAW'(1);
    end else if (32'(joint_count_r) > MAX_BONES) begin
      n_cl = JAW'(MAX_BONES);
    end else begin
      n_cl = JAW'(joint_count_r);
    end
  end

  assign bl_w    = 32'(bone_length_r) << FRAC_BITS;
  assign bone_s  = (bl_w > 32'(SLEN_MAX)) ? SLEN_MAX : bl_w[SLW-1:0];
  assign stot_sh = rsp.sq >> (6'(FRAC_BITS) + 6'(bend_shift_r));

  always_comb begin
    jw_en   = 1'b0;
    jw_addr = '0;
    jw_data = '0;
    jr_addr = '0;
    priority case (st_r)
      ST_IDLE: begin
        if (in_valid && !in_mode && (32'(in_joint_index) <= MAX_BONES)) begin
          jw_en   = 1'b1;
          jw_addr = JAW'(in_joint_index);
          jw_data = {in_coord_x, in_coord_y};
        end else if (in_valid && in_mode) begin
          jw_en   = 1'b1;
          jw_addr = n_cl;
          jw_data = {in_coord_x, in_coord_y};
        end
      end
      ST_RSTART: begin
        jw_en   = 1'b1;
        jw_addr = n_r;
        jw_data = {tgt_x_r, tgt_y_r};
      end
      ST_WB: begin
        jw_en   = (op_r != OP_BEND);
        jw_addr = p_r;
        jw_data = {sat_c(CW'(base_x_r) + (CW+1)'(vox)),
                   sat_c(CW'(base_y_r) + (CW+1)'(voy))};
      end
      ST_F_A:  jr_addr = p_r;
      ST_F_B:  jr_addr = q_addr;
      ST_O_RD, ST_O_CAP: jr_addr = p_r;
      default: jr_addr = '0;
    endcase
  end

  assign bw_en = (st_r == ST_WB) && (op_r == OP_BEND);

  always_ff @(posedge clk) begin
    if (jw_en) begin
      jmem[jw_addr] <= jw_data;
    end
    if (bw_en) begin
      bmem[BAW'(p_r)] <= {vox, voy};
    end
    jrd_r <= jmem[jr_addr];
    brd_r <= bmem[BAW'(p_r - 1'b1)];
  end

  // operand forming for one bone step
  logic signed [CW:0]   px_b, py_b;
  logic signed [VW-1:0] qx_e, qy_e, vx_c, vy_c;
  logic                 add_bend;

  assign add_bend = (op_r == OP_BACK) && (r_r == 4'd0);
  assign px_b = (CW+1)'(pv_x_r) + (add_bend ? (CW+1)'($signed(brd_r[2*CW-1:CW])) : '0);
  assign py_b = (CW+1)'(pv_y_r) + (add_bend ? (CW+1)'($signed(brd_r[CW-1:0])) : '0);
  assign qx_e = VW'($signed(jrd_r[2*CW-1:CW]));
  assign qy_e = VW'($signed(jrd_r[CW-1:0]));

  always_comb begin
    if (op_r == OP_BEND) begin
      vx_c = qy_e - VW'(pv_y_r);
      vy_c = VW'(pv_x_r) - qx_e;
    end else begin
      vx_c = VW'(px_b) - qx_e;
      vy_c = VW'(py_b) - qy_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_BEND;
      req_r.start <= 1'b0;
      req_r.tot   <= 1'b0;
      out_valid_r <= 1'b0;
      p_r         <= '0;
      n_r         <= JAW'(1);
      r_r         <= '0;
    end else begin
      req_r.start <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc && in_mode) begin
            n_r     <= n_cl;
            tgt_x_r <= in_coord_x;
            tgt_y_r <= in_coord_y;
            st_r    <= ST_TOT;
          end
        end
        ST_TOT: begin
          req_r.start <= 1'b1;
          req_r.tot   <= 1'b1;
          req_r.vx    <= VW'(tgt_x_r) - qx_e;
          req_r.vy    <= VW'(tgt_y_r) - qy_e;
          req_r.slen  <= '0;
          st_r        <= ST_TOT_WAIT;
        end
        ST_TOT_WAIT: begin
          if (rsp.done) begin
            bend_s_r <= (stot_sh > SQW'(SLEN_MAX)) ? SLEN_MAX : stot_sh[SLW-1:0];
            op_r     <= OP_BEND;
            p_r      <= '0;
            st_r     <= ST_F_A;
          end
        end
        ST_F_A: st_r <= ST_F_B;
        ST_F_B: begin
          pv_x_r <= $signed(jrd_r[2*CW-1:CW]);
          pv_y_r <= $signed(jrd_r[CW-1:0]);
          st_r   <= ST_F_C;
        end
        ST_F_C: begin
          base_x_r    <= $signed(jrd_r[2*CW-1:CW]);
          base_y_r    <= $signed(jrd_r[CW-1:0]);
          req_r.start <= 1'b1;
          req_r.tot   <= 1'b0;
          req_r.vx    <= vx_c;
          req_r.vy    <= vy_c;
          req_r.slen  <= (op_r == OP_BEND) ? bend_s_r : bone_s;
          st_r        <= ST_V_WAIT;
        end
        ST_V_WAIT: begin
          if (rsp.done) begin
            st_r <= ST_WB;
          end
        end
        ST_WB: begin
          unique case (op_r)
            OP_BEND: begin
              if (p_r == n_r - 1'b1) begin
                r_r <= '0;
                if (iter_count_r == 4'd0) begin
                  p_r  <= JAW'(1);
                  st_r <= ST_O_RD;
                end else begin
                  st_r <= ST_RSTART;
                end
              end else begin
                p_r  <= p_r + 1'b1;
                st_r <= ST_F_A;
              end
            end
            OP_BACK: begin
              if (p_r == JAW'(1)) begin
                op_r <= OP_FWD;
              end else begin
                p_r <= p_r - 1'b1;
              end
              st_r <= ST_F_A;
            end
            OP_FWD: begin
              if (p_r == n_r) begin
                if ({1'b0, r_r} + 5'd1 == {1'b0, iter_count_r}) begin
                  p_r  <= JAW'(1);
                  st_r <= ST_O_RD;
                end else begin
                  r_r  <= r_r + 1'b1;
                  st_r <= ST_RSTART;
                end
              end else begin
                p_r  <= p_r + 1'b1;
                st_r <= ST_F_A;
              end
            end
            default: st_r <= ST_IDLE;
          endcase
        end
        ST_RSTART: begin
          // end joint on target, then backward pass (forward pass for one bone)
          if (n_r > JAW'(1)) begin
            op_r <= OP_BACK;
            p_r  <= n_r - 1'b1;
          end else begin
            op_r <= OP_FWD;
            p_r  <= JAW'(1);
          end
          st_r <= ST_F_A;
        end
        ST_O_RD: st_r <= ST_O_CAP;
        ST_O_CAP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_index_r <= 4'(p_r);
            out_x_r     <= $signed(jrd_r[2*CW-1:CW]);
            out_y_r     <= $signed(jrd_r[CW-1:0]);
            out_last_r  <= (p_r == n_r);
            if (p_r == n_r) begin
              st_r <= ST_IDLE;
            end else begin
              p_r  <= p_r + 1'b1;
              st_r <= ST_O_RD;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  pcik_vec_unit u_vec (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp),
    .ox    (vox),
    .oy    (voy)
  );

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/pcik_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcik_checker: port-level checks of the planar chain IK solver
// Watches the channels of the top level and flags ordering slips.
// -----------------------------------------------------------------------------
module pcik_checker import pcik_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  in_mode,
  input wire logic [3:0]            in_joint_index,
  input wire logic signed [CW-1:0]  in_coord_x,
  input wire logic signed [CW-1:0]  in_coord_y,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [3:0]            out_index,
  input wire logic signed [CW-1:0]  out_x,
  input wire logic signed [CW-1:0]  out_y,
  input wire logic                  out_last
);

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_mode) && $stable(in_joint_index)
      && $stable(in_coord_x) && $stable(in_coord_y))
    else $error("input changed while stalled");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_index) && $stable(out_last))
    else $error("result changed while stalled");

  // a solve occupies the block
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("ready right after a solve");

  // a load leaves the block ready for the next transaction
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> in_ready)
    else $error("load did not complete in one cycle");

  // nothing follows the end joint until a new solve
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after end joint");

endmodule

bind planar_chain_ik_solver pcik_checker u_pcik_checker (.*);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: self-checking bench for planar_chain_ik_solver
// Loads joints and solves toward random targets under random config and flow
// control, predicts every streamed joint in the bench and compares in order.
// -----------------------------------------------------------------------------
module tb;
  import pcik_pkg::*;

  typedef struct {
    logic [3:0]           idx;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } joint_res_t;

  class ik_scoreboard;
    longint     jx[9];
    longint     jy[9];
    longint     offx[8];
    longint     offy[8];
    int         n_cfg = 2;
    int         blen = 100;
    int         iters = 10;
    int         bshift = 7;
    joint_res_t pending_q[$];
    int         errors = 0;

    function longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function longint int_sqrt(longint v);
      longint res;
      longint b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function void rescale(longint vx, longint vy, longint slen,
                          output longint ox, output longint oy);
      longint s;
      longint len;
      s = vx * vx + vy * vy;
      if (s == 0) begin
        ox = 0;
        oy = 0;
        return;
      end
      len = int_sqrt(s << 12);
      ox = sat24(round_div(vx * slen * 64, len));
      oy = sat24(round_div(vy * slen * 64, len));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int val);
      case (idx)
        CFG_JOINT_COUNT: n_cfg = val & 15;
        CFG_BONE_LENGTH: blen = val & 12'hFFF;
        CFG_ITER_COUNT:  iters = val & 15;
        default:         bshift = val & 15;
      endcase
    endfunction

    function int bones();
      if (n_cfg < 1) return 1;
      if (n_cfg > 8) return 8;
      return n_cfg;
    endfunction

    function void note_input(logic mode, logic [3:0] jidx, logic signed [CW-1:0] cx,
                             logic signed [CW-1:0] cy);
      int         n;
      longint     dx, dy, stot, bend_s, bone_s, bx, by, px, py;
      joint_res_t r;
      if (!mode) begin
        if (jidx <= 8) begin
          jx[jidx] = cx;
          jy[jidx] = cy;
        end
        return;
      end
      n = bones();
      jx[n] = cx;
      jy[n] = cy;
      dx = jx[n] - jx[0];
      dy = jy[n] - jy[0];
      stot = dx * dx + dy * dy;
      bend_s = stot >> (8 + bshift);
      if (bend_s > 64'sd8388607) bend_s = 64'sd8388607;
      bone_s = longint'(blen) << 8;
      for (int i = 1; i <= n; i++)
        rescale(jy[i] - jy[i-1], jx[i-1] - jx[i], bend_s, offx[i-1], offy[i-1]);
      for (int rd = 0; rd < iters; rd++) begin
        jx[n] = cx;
        jy[n] = cy;
        for (int i = n; i > 1; i--) begin
          px = jx[i-1];
          py = jy[i-1];
          if (rd == 0) begin
            px += offx[i-2];
            py += offy[i-2];
          end
          rescale(px - jx[i], py - jy[i], bone_s, bx, by);
          jx[i-1] = sat24(jx[i] + bx);
          jy[i-1] = sat24(jy[i] + by);
        end
        for (int i = 0; i < n; i++) begin
          rescale(jx[i+1] - jx[i], jy[i+1] - jy[i], bone_s, bx, by);
          jx[i+1] = sat24(jx[i] + bx);
          jy[i+1] = sat24(jy[i] + by);
        end
      end
      for (int i = 1; i <= n; i++) begin
        r.idx = 4'(i);
        r.x = jx[i][23:0];
        r.y = jy[i][23:0];
        r.last = (i == n);
        pending_q.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [3:0] idx, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                      logic last);
      joint_res_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected joint %0d", idx));
        return;
      end
      e = pending_q.pop_front();
      if (idx !== e.idx)
        report_mismatch($sformatf("index %0d, want %0d", idx, e.idx));
      if (x !== e.x)
        report_mismatch($sformatf("joint %0d x %0d, want %0d", e.idx, x, e.x));
      if (y !== e.y)
        report_mismatch($sformatf("joint %0d y %0d, want %0d", e.idx, y, e.y));
      if (last !== e.last)
        report_mismatch($sformatf("joint %0d last %0b, want %0b", e.idx, last, e.last));
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_JOINT_COUNT;
  logic [CFG_DW-1:0]     cfg_wdata = '0;
  logic                  in_valid = 0;
  logic                  in_ready;
  logic                  in_mode = 0;
  logic [3:0]            in_joint_index = '0;
  logic signed [CW-1:0]  in_coord_x = '0;
  logic signed [CW-1:0]  in_coord_y = '0;
  logic                  out_valid;
  logic                  out_ready = 0;
  logic [3:0]            out_index;
  logic signed [CW-1:0]  out_x;
  logic signed [CW-1:0]  out_y;
  logic                  out_last;

  ik_scoreboard sb = new();
  bit           quiet = 0;
  bit           hold_req = 0;
  bit           loaded[9];
  int           idle_cycles = 0;

  planar_chain_ik_solver u_dut (.*);

  always #10 clk = ~clk;

  // result side: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(out_index, out_x, out_y, out_last);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 6000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 300000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task send_item(logic mode, logic [3:0] jidx, logic signed [CW-1:0] x,
                 logic signed [CW-1:0] y);
    if (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_joint_index <= jidx;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_input(mode, jidx, x, y);
    if (!mode && jidx <= 8) loaded[jidx] = 1;
  endtask

  function logic signed [CW-1:0] near_coord();
    if ($urandom_range(9) == 0) return CW'($urandom());
    return CW'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  // load any joint the solve would read that was never written
  task solve_toward(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    for (int i = 0; i < sb.bones(); i++)
      if (!loaded[i]) send_item(1'b0, 4'(i), near_coord(), near_coord());
    send_item(1'b1, 4'($urandom_range(15)), x, y);
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_cfg(int jc, int bl, int it, int bs);
    int vals[4];
    vals = '{jc, bl, it, bs};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= CFG_DW'(vals[i]);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task random_batch(int items);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < 35)
        send_item(1'b0, 4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8)),
                  near_coord(), near_coord());
      else
        solve_toward(near_coord(), near_coord());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config, ignored loads, extremes, zero-length bones
    send_item(1'b0, 4'd0, 24'sd0, 24'sd0);
    send_item(1'b0, 4'd1, 24'sd25600, 24'sd0);
    send_item(1'b0, 4'd9, CMAX, CMIN);
    send_item(1'b0, 4'd15, CMIN, CMAX);
    send_item(1'b1, 4'd0, 24'sd38400, 24'sd12800);
    send_item(1'b0, 4'd1, CMAX, CMIN);
    send_item(1'b1, 4'd15, CMIN, CMIN);
    send_item(1'b0, 4'd0, CMAX, CMAX);
    send_item(1'b1, 4'd3, CMIN, CMAX);
    send_item(1'b0, 4'd0, 24'sd512, -24'sd512);
    send_item(1'b0, 4'd1, 24'sd512, -24'sd512);
    send_item(1'b1, 4'd0, 24'sd512, -24'sd512);
    drain();
    write_cfg(1, 4095, 15, 0);
    solve_toward(CMAX, CMAX);
    solve_toward(-24'sd1, 24'sd1);
    drain();
    write_cfg(8, 1, 1, 15);
    solve_toward(24'sd100000, -24'sd70000);
    drain();
    write_cfg(0, 0, 0, 3);
    solve_toward(24'sd300, 24'sd700);
    drain();
    write_cfg(12, 50, 1, 9);
    solve_toward(-24'sd40000, 24'sd9000);
    drain();

    // pressure: long result stall while solves keep coming
    write_cfg(2, 60, 1, 7);
    hold_req = 1;
    random_batch(10);
    send_item(1'b0, 4'd2, near_coord(), near_coord());
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    random_batch(6);
    drain();

    // random phases, mostly short chains and few rounds
    for (int p = 0; p < 12; p++) begin
      quiet = (p == 5);
      if (p == 7)
        write_cfg(8, $urandom_range(4095), 15, $urandom_range(15));
      else
        write_cfg($urandom_range(0, 4), $urandom_range(4095), $urandom_range(0, 4),
                  $urandom_range(15));
      random_batch((p == 7) ? 2 : 10);
      drain();
    end
    quiet = 0;

    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
